### hdl/branch_and_condition_unit_defines.svh
// Assertion macros shared by the branch and condition unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BRANCH_AND_CONDITION_UNIT_DEFINES_SVH
`define BRANCH_AND_CONDITION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset-qualified
`define BCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, reset-qualified
`define BCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/bcu_pkg.sv
// Types and constants of the branch and condition unit.
// No dependencies; used by bcu_exec and branch_and_condition_unit.
package bcu_pkg;

	// Instruction kinds
	localparam logic [3:0] KIND_B     = 4'd0;
	localparam logic [3:0] KIND_BC    = 4'd1;
	localparam logic [3:0] KIND_BCLR  = 4'd2;
	localparam logic [3:0] KIND_BCCTR = 4'd3;
	localparam logic [3:0] KIND_AND   = 4'd4;
	localparam logic [3:0] KIND_OR    = 4'd5;
	localparam logic [3:0] KIND_XOR   = 4'd6;
	localparam logic [3:0] KIND_NAND  = 4'd7;
	localparam logic [3:0] KIND_NOR   = 4'd8;
	localparam logic [3:0] KIND_EQV   = 4'd9;
	localparam logic [3:0] KIND_ANDC  = 4'd10;
	localparam logic [3:0] KIND_ORC   = 4'd11;
	localparam logic [3:0] KIND_MCRF  = 4'd12;

	// BO field bit positions
	localparam int BO_IGNORE_COND = 4;
	localparam int BO_COND_VALUE  = 3;
	localparam int BO_NO_DECR     = 2;
	localparam int BO_ON_ZERO     = 1;

	// Sequential instruction step
	localparam logic [31:0] INSN_STEP = 32'd4;

	typedef struct packed {
		logic [3:0]  kind;
		logic [23:0] long_offset;
		logic [13:0] short_offset;
		logic        absolute;
		logic        save_return;
		logic [4:0]  branch_options;
		logic [4:0]  test_bit;
		logic [4:0]  dest_bit;
		logic [4:0]  first_bit;
		logic [4:0]  second_bit;
	} bcu_instr_t;

	// Architectural registers
	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] ctr;
		logic [31:0] lr;
		logic [31:0] cr;
	} bcu_arch_t;

	// Outcome of one instruction
	typedef struct packed {
		bcu_arch_t arch;
		logic      taken;
	} bcu_result_t;

endpackage

### hdl/bcu_exec.sv
// Single-pass execute logic: next PC, count, link and condition registers.
// Depends on bcu_pkg for the instruction and register types.
module bcu_exec (
	input  bcu_pkg::bcu_instr_t  instr,
	input  bcu_pkg::bcu_arch_t   cur,
	output bcu_pkg::bcu_result_t res
);

	logic [31:0] seq;
	logic [31:0] ext_li;
	logic [31:0] ext_bd;
	logic [31:0] ctr_new;
	logic [31:0] target;
	logic        is_branch;
	logic        dec;
	logic        cond_ok;
	logic        ctr_ok;
	logic        taken;
	logic        a_bit;
	logic        b_bit;
	logic        r_bit;
	logic [2:0]  dst_fld;
	logic [2:0]  src_fld;
	logic [3:0]  nib;
	logic [31:0] cr_new;

	assign seq    = cur.pc + bcu_pkg::INSN_STEP;
	assign ext_li = {{6{instr.long_offset[23]}}, instr.long_offset, 2'b00};
	assign ext_bd = {{16{instr.short_offset[13]}}, instr.short_offset, 2'b00};

	assign is_branch = (instr.kind == bcu_pkg::KIND_B) || (instr.kind == bcu_pkg::KIND_BC)
		|| (instr.kind == bcu_pkg::KIND_BCLR) || (instr.kind == bcu_pkg::KIND_BCCTR);

	// Condition and counter tests; the counter test sees the decremented value
	assign cond_ok = instr.branch_options[bcu_pkg::BO_IGNORE_COND]
		|| (cur.cr[instr.test_bit] == instr.branch_options[bcu_pkg::BO_COND_VALUE]);
	assign dec = ((instr.kind == bcu_pkg::KIND_BC) || (instr.kind == bcu_pkg::KIND_BCLR))
		&& !instr.branch_options[bcu_pkg::BO_NO_DECR];
	assign ctr_new = dec ? (cur.ctr - 32'd1) : cur.ctr;
	assign ctr_ok  = !dec || ((ctr_new != 32'd0) != instr.branch_options[bcu_pkg::BO_ON_ZERO]);

	// Branch target and taken flag
	always_comb begin
		target = seq;
		taken  = 1'b0;
		case (instr.kind)
			bcu_pkg::KIND_B: begin
				target = instr.absolute ? ext_li : (cur.pc + ext_li);
				taken  = 1'b1;
			end
			bcu_pkg::KIND_BC: begin
				target = instr.absolute ? ext_bd : (cur.pc + ext_bd);
				taken  = cond_ok && ctr_ok;
			end
			bcu_pkg::KIND_BCLR: begin
				target = {cur.lr[31:2], 2'b00};
				taken  = cond_ok && ctr_ok;
			end
			bcu_pkg::KIND_BCCTR: begin
				target = {ctr_new[31:2], 2'b00};
				taken  = cond_ok;
			end
			default: begin
				target = seq;
				taken  = 1'b0;
			end
		endcase
	end

	// Condition-bit logic result
	assign a_bit = cur.cr[instr.first_bit];
	assign b_bit = cur.cr[instr.second_bit];

	always_comb begin
		case (instr.kind)
			bcu_pkg::KIND_AND:  r_bit = a_bit & b_bit;
			bcu_pkg::KIND_OR:   r_bit = a_bit | b_bit;
			bcu_pkg::KIND_XOR:  r_bit = a_bit ^ b_bit;
			bcu_pkg::KIND_NAND: r_bit = ~(a_bit & b_bit);
			bcu_pkg::KIND_NOR:  r_bit = ~(a_bit | b_bit);
			bcu_pkg::KIND_EQV:  r_bit = ~(a_bit ^ b_bit);
			bcu_pkg::KIND_ANDC: r_bit = a_bit & ~b_bit;
			default:            r_bit = a_bit | ~b_bit;
		endcase
	end

	// Field f occupies word bits 4*(7-f)+3 .. 4*(7-f)
	assign dst_fld = 3'd7 - instr.dest_bit[4:2];
	assign src_fld = 3'd7 - instr.first_bit[4:2];
	assign nib     = cur.cr[{src_fld, 2'b00} +: 4];

	// Condition register update
	always_comb begin
		cr_new = cur.cr;
		case (instr.kind) inside
			[bcu_pkg::KIND_AND:bcu_pkg::KIND_ORC]: cr_new[instr.dest_bit] = r_bit;
			bcu_pkg::KIND_MCRF:                   cr_new[{dst_fld, 2'b00} +: 4] = nib;
			default:                              cr_new = cur.cr;
		endcase
	end

	assign res.arch.pc  = taken ? target : seq;
	assign res.arch.ctr = ctr_new;
	assign res.arch.lr  = (is_branch && instr.save_return) ? seq : cur.lr;
	assign res.arch.cr  = cr_new;
	assign res.taken    = taken;

endmodule

### hdl/branch_and_condition_unit.sv
// Branch and condition unit top level: stream ports, input and result registers.
// Depends on bcu_pkg, bcu_exec and branch_and_condition_unit_defines.svh.
//
// One decoded branch-unit instruction is taken per cycle while the result
// stream is not stalled, a rate set by the single-pass execute logic that reads
// and updates the architectural registers in the same cycle. Each yields one
// result carrying the next instruction address, the taken flag and the link,
// count and condition registers after the instruction, via the input register
// then the result register. A write of start_address also reloads the program
// counter; it must be made only while the unit is idle, which is not enforced.
`include "branch_and_condition_unit_defines.svh"

module branch_and_condition_unit (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: start_address
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data,
	// instruction stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata, low bit up: long_offset[23:0], short_offset[13:0], absolute,
	// save_return, branch_options[4:0], test_bit[4:0], dest_bit[4:0],
	// first_bit[4:0], second_bit[4:0], zero fill to 72 bits
	input  logic [71:0]  s_tdata,
	// tuser: kind[3:0]
	input  logic [3:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata, low bit up: next_address[31:0], taken, link_value[31:0],
	// count_value[31:0], condition_value[31:0], zero fill to 136 bits
	output logic [135:0] m_tdata
);

	bcu_pkg::bcu_instr_t  instr_in;
	bcu_pkg::bcu_instr_t  instr_s1;
	logic                 valid_s1;
	bcu_pkg::bcu_arch_t   arch_q;
	bcu_pkg::bcu_result_t exec_res;
	bcu_pkg::bcu_result_t res_q;
	logic                 out_valid_q;
	logic                 adv;

	// Field unpacking
	assign instr_in.kind           = s_tuser;
	assign instr_in.long_offset    = s_tdata[23:0];
	assign instr_in.short_offset   = s_tdata[37:24];
	assign instr_in.absolute       = s_tdata[38];
	assign instr_in.save_return    = s_tdata[39];
	assign instr_in.branch_options = s_tdata[44:40];
	assign instr_in.test_bit       = s_tdata[49:45];
	assign instr_in.dest_bit       = s_tdata[54:50];
	assign instr_in.first_bit      = s_tdata[59:55];
	assign instr_in.second_bit     = s_tdata[64:60];

	// Handshake: execute when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			instr_s1 <= instr_in;
		end
	end

	bcu_exec u_exec (
		.instr (instr_s1),
		.cur   (arch_q),
		.res   (exec_res)
	);

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
		end else if (cfg_wr_en) begin
			arch_q.pc <= cfg_wr_data;
		end else if (adv) begin
			arch_q <= exec_res.arch;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= exec_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, res_q.arch.cr, res_q.arch.ctr, res_q.arch.lr, res_q.taken,
		res_q.arch.pc};

	// Checks
	`BCU_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !valid_s1, s_tready, "input register empty but not ready")
	`BCU_ASSERT_NEXT(a_adv_gives_result, clk, arst_n, adv, m_tvalid, "executed instruction left no result")
	`BCU_ASSERT_NEXT(a_seq_pc, clk, arst_n, adv && !exec_res.taken, arch_q.pc == ($past(arch_q.pc) + bcu_pkg::INSN_STEP), "untaken instruction did not step the PC")
	`BCU_ASSERT_NEXT(a_unused_kind_quiet, clk, arst_n, adv && (instr_s1.kind > bcu_pkg::KIND_MCRF), (arch_q.cr == $past(arch_q.cr)) && (arch_q.ctr == $past(arch_q.ctr)) && (arch_q.lr == $past(arch_q.lr)), "unused kind changed a register")

endmodule
